>>> design/mmsphp_pkg.sv
// Shared types, codes and constants of the MMS PDU header parser.
// Used by mmsphp_step and mms_pdu_header_parser_unit; depends on nothing.
`default_nettype none

package mmsphp_pkg;

   // Widest invoke identifier accepted, in bytes, and width of the length field.
   localparam int INVOKE_MAX_BYTES = 4;
   localparam int LENGTH_BITS      = 16;

   // The one counter serves the length field (one or two bytes) and the invoke bytes.
   localparam int CNT_BITS_RAW = $clog2(INVOKE_MAX_BYTES + 1);
   localparam int CNT_BITS     = (CNT_BITS_RAW < 2) ? 2 : CNT_BITS_RAW;

   // Tag and marker byte values.
   localparam logic [7:0] TAG_UP        = 8'ha0;
   localparam logic [7:0] TAG_DOWN      = 8'ha1;
   localparam logic [7:0] TAG_INVOKE    = 8'h02;
   localparam logic [7:0] LEN_LONG1     = 8'h81;
   localparam logic [7:0] LEN_LONG2     = 8'h82;
   localparam logic [7:0] TAG_EXT       = 8'hbf;
   localparam logic [7:0] TAG_FILE_DIR  = 8'h4d;
   localparam logic [7:0] TAG_READ      = 8'ha4;
   localparam logic [7:0] INVOKE_MAX_B  = 8'(INVOKE_MAX_BYTES);

   // Parser phases.
   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_SEEK  = 4'd1;
   localparam logic [3:0] PH_LEN0  = 4'd2;
   localparam logic [3:0] PH_LENX  = 4'd3;
   localparam logic [3:0] PH_ITAG  = 4'd4;
   localparam logic [3:0] PH_ISIZE = 4'd5;
   localparam logic [3:0] PH_IDATA = 4'd6;
   localparam logic [3:0] PH_SVC   = 4'd7;
   localparam logic [3:0] PH_SVC2  = 4'd8;
   localparam logic [3:0] PH_DONE  = 4'd9;

   // Result status codes.
   localparam logic [3:0] ST_FILE_DIR   = 4'd0;
   localparam logic [3:0] ST_READ       = 4'd1;
   localparam logic [3:0] ST_OTHER      = 4'd2;
   localparam logic [3:0] ST_NO_DIR     = 4'd3;
   localparam logic [3:0] ST_BAD_LEN    = 4'd4;
   localparam logic [3:0] ST_LEN_MISM   = 4'd5;
   localparam logic [3:0] ST_BAD_ITAG   = 4'd6;
   localparam logic [3:0] ST_WIDE_INV   = 4'd7;
   localparam logic [3:0] ST_TRUNCATED  = 4'd8;

   typedef struct packed {
      logic [3:0]             phase;
      logic [15:0]            byte_position;
      logic [LENGTH_BITS-1:0] declared_length;
      logic [31:0]            invoke_value;
      logic [CNT_BITS-1:0]    bytes_left;
      logic                   direction_seen;
      logic [15:0]            pkt_length;
      logic [15:0]            tag_index;
   } state_type;

   typedef struct packed {
      logic [3:0]  status;
      logic        direction;
      logic [31:0] invoke_number;
      logic [15:0] service_offset;
   } result_type;

endpackage

`default_nettype wire

>>> design/mmsphp_step.sv
// Next-state and result logic for one packet byte of the header parser.
// Purely combinational; depends on mmsphp_pkg.
`default_nettype none

module mmsphp_step (
   input  wire mmsphp_pkg::state_type  cur_state,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   start_of_packet,
   input  wire logic                   last_byte,
   input  wire logic [15:0]            packet_length,
   output mmsphp_pkg::state_type       next_state,
   output logic                        emit,
   output mmsphp_pkg::result_type      result
);
   import mmsphp_pkg::*;

   state_type           st;
   logic                len_check;
   logic                with_inv;
   logic [3:0]          status;
   logic [15:0]         offset;
   logic [16:0]         after;
   logic                mismatch;
   logic [CNT_BITS-1:0] cnt_dec;

   always_comb begin
      st        = cur_state;
      len_check = 1'b0;
      emit      = 1'b0;
      with_inv  = 1'b0;
      status    = ST_OTHER;
      offset    = '0;
      if (start_of_packet) begin
         st            = '0;
         st.pkt_length = packet_length;
         st.phase      = PH_SEEK;
      end
      after    = {1'b0, st.byte_position} + 17'd1;
      mismatch = (after > {1'b0, st.pkt_length});
      cnt_dec  = st.bytes_left - CNT_BITS'(1);

      if (st.phase != PH_IDLE && st.phase != PH_DONE) begin
         unique case (st.phase)
            PH_SEEK: begin
               if (data_byte == TAG_UP || data_byte == TAG_DOWN) begin
                  st.direction_seen = (data_byte == TAG_DOWN);
                  st.phase          = PH_LEN0;
               end
            end
            PH_LEN0: begin
               if (data_byte < LEN_LONG1) begin
                  st.declared_length = LENGTH_BITS'(data_byte);
                  len_check          = 1'b1;
               end else if (data_byte == LEN_LONG1 || data_byte == LEN_LONG2) begin
                  st.declared_length = '0;
                  st.bytes_left      = CNT_BITS'(data_byte[1:0]);
                  st.phase           = PH_LENX;
               end else begin
                  emit   = 1'b1;
                  status = ST_BAD_LEN;
                  offset = st.byte_position;
               end
            end
            PH_LENX: begin
               st.declared_length = LENGTH_BITS'({st.declared_length, data_byte});
               st.bytes_left      = cnt_dec;
               len_check          = (cnt_dec == '0);
            end
            PH_ITAG: begin
               if (data_byte != TAG_INVOKE) begin
                  emit   = 1'b1;
                  status = ST_BAD_ITAG;
                  offset = st.byte_position;
               end else begin
                  st.phase = PH_ISIZE;
               end
            end
            PH_ISIZE: begin
               if (data_byte > INVOKE_MAX_B) begin
                  emit   = 1'b1;
                  status = ST_WIDE_INV;
                  offset = st.byte_position - 16'd1;
               end else begin
                  st.invoke_value = '0;
                  st.bytes_left   = CNT_BITS'(data_byte);
                  st.phase        = (data_byte == 8'd0) ? PH_SVC : PH_IDATA;
               end
            end
            PH_IDATA: begin
               st.invoke_value = {st.invoke_value[23:0], data_byte};
               st.bytes_left   = cnt_dec;
               if (cnt_dec == '0) begin
                  st.phase = PH_SVC;
               end
            end
            PH_SVC: begin
               st.tag_index = st.byte_position;
               if (data_byte == TAG_READ) begin
                  emit     = 1'b1;
                  status   = ST_READ;
                  with_inv = 1'b1;
                  offset   = st.byte_position;
               end else if (data_byte == TAG_EXT) begin
                  st.phase = PH_SVC2;
               end else begin
                  emit     = 1'b1;
                  status   = ST_OTHER;
                  with_inv = 1'b1;
                  offset   = st.byte_position;
               end
            end
            PH_SVC2: begin
               emit     = 1'b1;
               status   = (data_byte == TAG_FILE_DIR) ? ST_FILE_DIR : ST_OTHER;
               with_inv = 1'b1;
               offset   = st.tag_index;
            end
            default: begin
            end
         endcase

         // The declared length must match the bytes that follow the length field.
         if (len_check) begin
            if (mismatch || (16'(st.declared_length) != (st.pkt_length - after[15:0])))
            begin
               emit   = 1'b1;
               status = ST_LEN_MISM;
               offset = after[15:0];
            end else begin
               st.phase = PH_ITAG;
            end
         end

         // Packet ended before the outcome was settled.
         if (!emit && last_byte) begin
            emit     = 1'b1;
            status   = (st.phase == PH_SEEK) ? ST_NO_DIR : ST_TRUNCATED;
            with_inv = (st.phase == PH_SVC) || (st.phase == PH_SVC2);
            offset   = after[15:0];
         end

         if (emit) begin
            st.phase = PH_DONE;
         end
         st.byte_position = after[15:0];
      end

      next_state            = st;
      result.status         = status;
      result.direction      = st.direction_seen;
      result.invoke_number  = with_inv ? st.invoke_value : 32'd0;
      result.service_offset = offset;
   end

endmodule

`default_nettype wire

>>> design/mms_pdu_header_parser_unit.sv
// Top level of the MMS PDU header parser: input beat register, parser state and
// result register. Depends on mmsphp_pkg and mmsphp_step.
//
// Usage: packet bytes enter on the req_ channel, one byte per beat, with
// req_start_of_packet on the first byte (which also samples req_packet_length)
// and req_last_byte on the final one. For each packet the block returns exactly
// one status beat on the rsp_ channel, produced by the byte on which the outcome
// is settled; the remaining bytes of that packet are consumed without a result.
// A start of packet in the middle of a packet silently drops the old one.
//
// The byte that settles the result is first captured in the input register, and
// its result is then loaded into the result register that drives rsp_valid; a
// waiting result can hold the byte in the input register in between.
// Throughput: one byte per cycle while no result waits on rsp_ready; the parser
// state advances once per byte through the combinational logic of mmsphp_step.
//
// Stalls: when rsp_ready is low with a result waiting, the input register holds
// its byte and req_ready falls once that register is occupied. As soon as the
// result is taken the pipeline moves on in the same cycle, so no bubble follows.
//
// Reset (synchronous, active high) empties both registers and returns the parser
// to idle; bytes without a start of packet are then ignored.
`default_nettype none

module mms_pdu_header_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_start_of_packet,
   input  wire logic        req_last_byte,
   input  wire logic [15:0] req_packet_length,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_status,
   output logic             rsp_direction,
   output logic [31:0]      rsp_invoke_number,
   output logic [15:0]      rsp_service_offset
);
   import mmsphp_pkg::*;

   // Input beat register.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_sop_ff;
   logic        in_last_ff;
   logic [15:0] in_len_ff;

   // Parser state and result register.
   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;

   logic        advance;
   logic        req_fire;
   logic        step_emit;
   result_type  step_result;

   // The held byte is processed when the result register is free or being emptied.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   mmsphp_step u_step (
      .cur_state       (state_ff),
      .data_byte       (in_byte_ff),
      .start_of_packet (in_sop_ff),
      .last_byte       (in_last_ff),
      .packet_length   (in_len_ff),
      .next_state      (state_in),
      .emit            (step_emit),
      .result          (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      priority if (advance) begin
         rsp_valid_in = step_emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_data_byte;
         in_sop_ff  <= req_start_of_packet;
         in_last_ff <= req_last_byte;
         in_len_ff  <= req_packet_length;
      end
      if (advance && step_emit) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_direction      = rsp_ff.direction;
   assign rsp_invoke_number  = rsp_ff.invoke_number;
   assign rsp_service_offset = rsp_ff.service_offset;

   // The input side only stalls behind a waiting result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without a stalled result");

   // Status codes stay inside the defined set.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_TRUNCATED))
      else $error("undefined status code");

   // Without a direction tag nothing else of the header was decoded.
   a_no_dir_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_NO_DIR)
      |-> (!rsp_direction && rsp_invoke_number == 32'd0))
      else $error("no-direction result carries header fields");

   // Errors before the invoke identifier never report one.
   a_early_err_inv: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_BAD_LEN || rsp_status == ST_LEN_MISM ||
                     rsp_status == ST_BAD_ITAG || rsp_status == ST_WIDE_INV))
      |-> (rsp_invoke_number == 32'd0))
      else $error("invoke identifier reported on an early error");

endmodule

`default_nettype wire
